[design/dss_pkg.sv]
package dss_pkg;

    localparam logic [1:0] SIGN_ZERO  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [4:0] RADIX     = 5'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_SUB_RD,
        ST_SUB_WR,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_ZERO_OUT
    } dss_state_t;

    // digit write from the loader into the operand stores
    typedef struct packed {
        logic       we_first;
        logic       we_second;
        logic [3:0] digit;
    } dss_wr_t;

endpackage

[design/dss_front.sv]
module dss_front
    import dss_pkg::*;
#(
    parameter int MAX_DIGITS = 64,
    parameter int LW         = 7,
    parameter int AW         = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tuser,
    input  logic            s_tlast,
    output dss_wr_t         wr,
    output logic [AW-1:0]   wr_addr,
    output logic            q_push,
    output logic [2*LW:0]   q_data,
    input  logic            q_full,
    input  logic            done
);

    logic [LW-1:0] la_reg, la_next;
    logic [LW-1:0] lb_reg, lb_next;
    logic          ovf_reg, ovf_next;
    logic          hold_reg, hold_next;
    logic          accept;
    logic [3:0]    digit_sat;
    logic          a_room, b_room;

    assign s_tready  = !hold_reg && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign digit_sat = (s_tdata[3:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[3:0];
    assign a_room    = la_reg < LW'(MAX_DIGITS);
    assign b_room    = lb_reg < LW'(MAX_DIGITS);

    always_comb begin
        la_next      = la_reg;
        lb_next      = lb_reg;
        ovf_next     = ovf_reg;
        hold_next    = hold_reg;
        wr.we_first  = 1'b0;
        wr.we_second = 1'b0;
        wr.digit     = digit_sat;
        wr_addr      = (s_tuser == OP_FIRST) ? la_reg[AW-1:0] : lb_reg[AW-1:0];
        q_push       = 1'b0;
        if (done) begin
            hold_next = 1'b0;
        end
        if (accept) begin
            if (s_tuser == OP_FIRST) begin
                if (a_room) begin
                    wr.we_first = 1'b1;
                    la_next     = la_reg + LW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end else begin
                if (b_room) begin
                    wr.we_second = 1'b1;
                    lb_next      = lb_reg + LW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end
        q_data = {ovf_next, lb_next, la_next};
        // final digit of the second operand hands the pair to the back end
        if (accept && s_tuser == OP_SECOND && s_tlast) begin
            q_push    = 1'b1;
            la_next   = '0;
            lb_next   = '0;
            ovf_next  = 1'b0;
            hold_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la_reg   <= '0;
            lb_reg   <= '0;
            ovf_reg  <= 1'b0;
            hold_reg <= 1'b0;
        end else begin
            la_reg   <= la_next;
            lb_reg   <= lb_next;
            ovf_reg  <= ovf_next;
            hold_reg <= hold_next;
        end
    end

endmodule

[design/dss_fifo.sv]
module dss_fifo #(
    parameter int W = 15
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) begin
                wp_reg <= !wp_reg;
            end
            if (pop && !empty) begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end

endmodule

[design/dss_back.sv]
module dss_back
    import dss_pkg::*;
#(
    parameter int MAX_DIGITS = 64,
    parameter int LW         = 7,
    parameter int AW         = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dss_wr_t         wr,
    input  logic [AW-1:0]   wr_addr,
    output logic            q_pop,
    input  logic [2*LW:0]   q_data,
    input  logic            q_empty,
    output logic            done,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    logic [3:0] first_mem  [MAX_DIGITS];
    logic [3:0] second_mem [MAX_DIGITS];
    logic [3:0] diff_mem   [MAX_DIGITS];

    dss_state_t    state_reg, state_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] la_reg, la_next;
    logic [LW-1:0] lb_reg, lb_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [1:0]    sign_reg, sign_next;
    logic          borrow_reg, borrow_next;
    logic          nz_reg, nz_next;

    logic [3:0]    rd_a_reg, rd_b_reg, rd_d_reg;
    logic [LW-1:0] pos_a, pos_b;
    logic [3:0]    a_val, b_val, x_val, y_val, d_val;
    logic [4:0]    sub5;
    logic          diff_we;

    logic          out_valid_reg;
    logic [1:0]    out_sign_reg;
    logic [3:0]    out_digit_reg;
    logic          out_last_reg, out_ovf_reg;
    logic          out_free, out_load;
    logic [1:0]    out_sign;
    logic [3:0]    out_digit;
    logic          out_last;

    logic [LW-1:0] q_la, q_lb;
    logic          q_ovf;

    assign {q_ovf, q_lb, q_la} = q_data;

    // digit position i counts from the least significant end
    assign pos_a = la_reg - i_reg - LW'(1);
    assign pos_b = lb_reg - i_reg - LW'(1);
    assign a_val = (i_reg < la_reg) ? rd_a_reg : 4'd0;
    assign b_val = (i_reg < lb_reg) ? rd_b_reg : 4'd0;

    always_ff @(posedge aclk) begin
        if (wr.we_first) begin
            first_mem[wr_addr] <= wr.digit;
        end
        if (wr.we_second) begin
            second_mem[wr_addr] <= wr.digit;
        end
        rd_a_reg <= first_mem[pos_a[AW-1:0]];
        rd_b_reg <= second_mem[pos_b[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (diff_we) begin
            diff_mem[i_reg[AW-1:0]] <= d_val;
        end
        rd_d_reg <= diff_mem[i_reg[AW-1:0]];
    end

    // decimal subtract of one digit pair
    always_comb begin
        x_val = (sign_reg == SIGN_PLUS) ? a_val : b_val;
        y_val = (sign_reg == SIGN_PLUS) ? b_val : a_val;
        sub5  = {1'b0, y_val} + {4'd0, borrow_reg};
        if ({1'b0, x_val} >= sub5) begin
            d_val        = x_val - sub5[3:0];
            borrow_next  = 1'b0;
        end else begin
            d_val        = 4'(({1'b0, x_val} + RADIX) - sub5);
            borrow_next  = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        sign_next  = sign_reg;
        nz_next    = nz_reg;
        q_pop      = 1'b0;
        diff_we    = 1'b0;
        done       = 1'b0;
        out_load   = 1'b0;
        out_sign   = sign_reg;
        out_digit  = rd_d_reg;
        out_last   = i_reg == '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    la_next  = q_la;
                    lb_next  = q_lb;
                    ovf_next = q_ovf;
                    len_next = (q_la > q_lb) ? q_la : q_lb;
                    if (q_la == '0 && q_lb == '0) begin
                        state_next = ST_ZERO_OUT;
                    end else begin
                        i_next     = ((q_la > q_lb) ? q_la : q_lb) - LW'(1);
                        state_next = ST_CMP_RD;
                    end
                end
            end
            ST_CMP_RD: begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK: begin
                if (a_val != b_val) begin
                    sign_next  = (a_val > b_val) ? SIGN_PLUS : SIGN_MINUS;
                    i_next     = '0;
                    state_next = ST_SUB_RD;
                end else if (i_reg == '0) begin
                    state_next = ST_ZERO_OUT;
                end else begin
                    i_next     = i_reg - LW'(1);
                    state_next = ST_CMP_RD;
                end
            end
            ST_SUB_RD: begin
                state_next = ST_SUB_WR;
            end
            ST_SUB_WR: begin
                diff_we = 1'b1;
                if (i_reg == len_reg - LW'(1)) begin
                    nz_next    = 1'b0;
                    state_next = ST_EMIT_RD;
                end else begin
                    i_next     = i_reg + LW'(1);
                    state_next = ST_SUB_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK: begin
                // a nonzero digit always lies below, so skipping never runs out
                if (rd_d_reg == 4'd0 && !nz_reg) begin
                    i_next     = i_reg - LW'(1);
                    state_next = ST_EMIT_RD;
                end else if (out_free) begin
                    out_load = 1'b1;
                    nz_next  = 1'b1;
                    if (i_reg == '0) begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg - LW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_ZERO_OUT: begin
                out_sign  = SIGN_ZERO;
                out_digit = 4'd0;
                out_last  = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg      <= '0;
            la_reg     <= '0;
            lb_reg     <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            sign_reg   <= SIGN_ZERO;
            borrow_reg <= 1'b0;
            nz_reg     <= 1'b0;
        end else begin
            i_reg    <= i_next;
            la_reg   <= la_next;
            lb_reg   <= lb_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            sign_reg <= sign_next;
            nz_reg   <= nz_next;
            if (state_reg == ST_CMP_CHK) begin
                borrow_reg <= 1'b0;
            end else if (diff_we) begin
                borrow_reg <= borrow_next;
            end
        end
    end

    // output register decouples the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_sign_reg  <= out_sign;
            out_digit_reg <= out_digit;
            out_last_reg  <= out_last;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_digit_reg};
    assign m_tuser  = {out_ovf_reg, out_sign_reg};
    assign m_tlast  = out_last_reg;

    a_no_leading_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !nz_reg |-> (out_digit != 4'd0) || out_last)
        else $error("leading zero digit emitted");

    a_zero_single: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_sign == SIGN_ZERO |-> out_last)
        else $error("zero result spans more than one digit");

    a_sign_known: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUB_WR || state_reg == ST_EMIT_CHK
        |-> sign_reg == SIGN_PLUS || sign_reg == SIGN_MINUS)
        else $error("subtract or emit without a decided sign");

    a_no_final_borrow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUB_WR && i_reg == len_reg - LW'(1) |-> !borrow_next)
        else $error("borrow out of the top digit");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> state_reg == ST_IDLE && m_tvalid)
        else $error("done without a pending result");

endmodule

[design/decimal_string_subtractor.sv]
// channel   direction  tdata                 tuser                      tlast
// s_        in         [3:0] digit           [0] operation              last_digit
// m_        out        [3:0] result_digit    [1:0] sign, [2] overflow   last_result
//
// digits load at one per cycle while s_tready is high; the final digit of the second operand
// starts the work on a pair: compare from the top digit, subtract from the bottom digit, then
// read back from the top; each step is one read of a store with registered read data
// while the back end works on a pair, no new digit is taken (s_tready low)
// reset is synchronous; operand and difference stores are not cleared
// results wait in an output register, so a stalled m_tready only holds the back end
module decimal_string_subtractor
    import dss_pkg::*;
#(
    parameter int MAX_DIGITS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [3:0] digit
    input  logic       s_tuser,   // [0] operation
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] result_digit
    output logic [2:0] m_tuser,   // [1:0] sign, [2] overflow
    output logic       m_tlast
);

    localparam int LW = $clog2(MAX_DIGITS + 1);
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int QW = 2 * LW + 1;

    dss_wr_t       wr;
    logic [AW-1:0] wr_addr;
    logic          q_push, q_pop, q_full, q_empty, done;
    logic [QW-1:0] q_in, q_out;

    dss_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .LW         (LW),
        .AW         (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full),
        .done     (done)
    );

    dss_fifo #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    dss_back #(
        .MAX_DIGITS (MAX_DIGITS),
        .LW         (LW),
        .AW         (AW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .q_pop    (q_pop),
        .q_data   (q_out),
        .q_empty  (q_empty),
        .done     (done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
